### rtl/assert_macros.svh
// Assertion macros used by the indexed list datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ILIST_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ILIST_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/ilist_pkg.sv
// Types and constants shared by the indexed list controller, datapath and top level.
package ilist_pkg;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned ADDR_W    = $clog2(DEPTH);
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned INDEX_W   = 5;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 48;

  localparam logic [CMD_W-1:0] CMD_GET    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FIND   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam logic [INDEX_W-1:0] FOUND_NONE = '1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_FAIL_RANGE,
    OP_FAIL_FULL,
    OP_SET,
    OP_RD_IDX,
    OP_GET_DONE,
    OP_UP_START,
    OP_UP_STEP,
    OP_INS_WR,
    OP_DN_START,
    OP_DN_STEP,
    OP_DN_LAST,
    OP_DEC,
    OP_FIND_START,
    OP_FIND_STEP
  } dp_op_e;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             range_err;
    logic             full;
    logic             ins_direct;
    logic             dn_none;
    logic             up_last;
    logic             dn_last;
    logic             find_last;
    logic             match;
    logic             cnt_zero;
  } dp_stat_t;

endpackage

### rtl/ilist_dp.sv
// Indexed list datapath: entry memory, live count, walk pointer and result registers.
`include "assert_macros.svh"

module ilist_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ilist_pkg::dp_op_e                  op_i,
  input  logic [ilist_pkg::CMD_W-1:0]        cmd_i,
  input  logic [ilist_pkg::INDEX_W-1:0]      index_i,
  input  logic [ilist_pkg::VALUE_W-1:0]      value_i,
  output ilist_pkg::dp_stat_t                stat_o,
  output logic [ilist_pkg::VALUE_W-1:0]      read_value_o,
  output logic signed [ilist_pkg::INDEX_W-1:0] found_index_o,
  output logic [ilist_pkg::STATUS_W-1:0]     status_o,
  output logic [ilist_pkg::COUNT_W-1:0]      count_o
);

  localparam int unsigned EXT_W = ilist_pkg::COUNT_W + 1;

  logic [ilist_pkg::VALUE_W-1:0]  mem_q [ilist_pkg::DEPTH];
  logic [ilist_pkg::VALUE_W-1:0]  rdata_q;
  logic [ilist_pkg::CMD_W-1:0]    cmd_q;
  logic [ilist_pkg::INDEX_W-1:0]  idx_q;
  logic [ilist_pkg::VALUE_W-1:0]  val_q;
  logic [ilist_pkg::COUNT_W-1:0]  ptr_q, ptr_d;
  logic [ilist_pkg::COUNT_W-1:0]  count_q, count_d;
  logic [ilist_pkg::VALUE_W-1:0]  rd_val_q;
  logic [ilist_pkg::INDEX_W-1:0]  found_q;
  logic [ilist_pkg::STATUS_W-1:0] status_q;

  logic                           wr_en, rd_en;
  logic [ilist_pkg::COUNT_W-1:0]  wr_ptr, rd_ptr;
  logic [ilist_pkg::VALUE_W-1:0]  wr_data;
  logic [EXT_W-1:0]               idx_x, cnt_x, ptr_x;

  assign idx_x = {1'b0, idx_q};
  assign cnt_x = {1'b0, count_q};
  assign ptr_x = {1'b0, ptr_q};

  always_comb begin
    stat_o.cmd        = cmd_q;
    stat_o.range_err  = (cmd_q == ilist_pkg::CMD_INSERT) ? (idx_q > count_q)
                                                         : (idx_q >= count_q);
    stat_o.full       = (count_q == ilist_pkg::COUNT_W'(ilist_pkg::DEPTH));
    stat_o.ins_direct = (idx_q == count_q);
    stat_o.dn_none    = ((idx_x + EXT_W'(1)) >= cnt_x);
    stat_o.up_last    = (ptr_x == (idx_x + EXT_W'(1)));
    stat_o.dn_last    = ((ptr_x + EXT_W'(2)) >= cnt_x);
    stat_o.find_last  = ((ptr_x + EXT_W'(1)) == cnt_x);
    stat_o.match      = (rdata_q == val_q);
    stat_o.cnt_zero   = (count_q == '0);
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_ptr  = ptr_q;
    wr_data = rdata_q;
    rd_en   = 1'b0;
    rd_ptr  = ptr_q;
    ptr_d   = ptr_q;
    count_d = count_q;
    case (op_i)
      ilist_pkg::OP_SET: begin
        wr_en   = 1'b1;
        wr_ptr  = idx_q;
        wr_data = val_q;
      end
      ilist_pkg::OP_RD_IDX: begin
        rd_en  = 1'b1;
        rd_ptr = idx_q;
      end
      ilist_pkg::OP_UP_START: begin
        rd_en  = 1'b1;
        rd_ptr = count_q - 1'b1;
        ptr_d  = count_q;
      end
      ilist_pkg::OP_UP_STEP: begin
        wr_en  = 1'b1;
        rd_en  = 1'b1;
        rd_ptr = ptr_q - 2'd2;
        ptr_d  = ptr_q - 1'b1;
      end
      ilist_pkg::OP_INS_WR: begin
        wr_en   = 1'b1;
        wr_ptr  = idx_q;
        wr_data = val_q;
        count_d = count_q + 1'b1;
      end
      ilist_pkg::OP_DN_START: begin
        rd_en  = 1'b1;
        rd_ptr = idx_q + 1'b1;
        ptr_d  = idx_q;
      end
      ilist_pkg::OP_DN_STEP: begin
        wr_en  = 1'b1;
        rd_en  = 1'b1;
        rd_ptr = ptr_q + 2'd2;
        ptr_d  = ptr_q + 1'b1;
      end
      ilist_pkg::OP_DN_LAST: begin
        wr_en   = 1'b1;
        count_d = count_q - 1'b1;
      end
      ilist_pkg::OP_DEC: begin
        count_d = count_q - 1'b1;
      end
      ilist_pkg::OP_FIND_START: begin
        rd_en  = 1'b1;
        rd_ptr = '0;
        ptr_d  = '0;
      end
      ilist_pkg::OP_FIND_STEP: begin
        rd_en  = 1'b1;
        rd_ptr = ptr_q + 1'b1;
        ptr_d  = ptr_q + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr[ilist_pkg::ADDR_W-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_ptr[ilist_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    case (op_i)
      ilist_pkg::OP_LOAD: begin
        cmd_q    <= cmd_i;
        idx_q    <= index_i;
        val_q    <= value_i;
        rd_val_q <= '0;
        found_q  <= ilist_pkg::FOUND_NONE;
        status_q <= ilist_pkg::ST_OK;
      end
      ilist_pkg::OP_FAIL_RANGE: status_q <= ilist_pkg::ST_RANGE;
      ilist_pkg::OP_FAIL_FULL:  status_q <= ilist_pkg::ST_FULL;
      ilist_pkg::OP_GET_DONE:   rd_val_q <= rdata_q;
      ilist_pkg::OP_FIND_STEP: begin
        if (stat_o.match) begin
          found_q <= ptr_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign read_value_o  = rd_val_q;
  assign found_index_o = found_q;
  assign status_o      = status_q;
  assign count_o       = count_q;

  `ILIST_ASSERT(a_count_bound, count_q <= ilist_pkg::COUNT_W'(ilist_pkg::DEPTH), "count above depth")
  `ILIST_ASSERT_IMP(a_count_step, count_q != $past(count_q), (count_q == $past(count_q) + 1'b1) || (count_q == $past(count_q) - 1'b1), "count moved by more than one")
  `ILIST_ASSERT_IMP(a_find_in_range, op_i == ilist_pkg::OP_FIND_STEP, ptr_q < count_q, "find walked past count")
  `ILIST_ASSERT_IMP(a_up_above_idx, op_i == ilist_pkg::OP_UP_STEP, ptr_q > idx_q, "shift up below index")

endmodule

### rtl/ilist_ctrl.sv
// Indexed list controller: sequences each command beat through the datapath.
module ilist_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  ilist_pkg::dp_stat_t  stat_i,
  output ilist_pkg::dp_op_e    op_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHECK = 8'b0000_0010,
    S_GET   = 8'b0000_0100,
    S_UP    = 8'b0000_1000,
    S_INS   = 8'b0001_0000,
    S_DN    = 8'b0010_0000,
    S_FIND  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    op_o    = ilist_pkg::OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o    = ilist_pkg::OP_LOAD;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = S_OUT;
        case (stat_i.cmd)
          ilist_pkg::CMD_GET: begin
            if (stat_i.range_err) begin
              op_o = ilist_pkg::OP_FAIL_RANGE;
            end else begin
              op_o    = ilist_pkg::OP_RD_IDX;
              state_d = S_GET;
            end
          end
          ilist_pkg::CMD_SET: begin
            op_o = stat_i.range_err ? ilist_pkg::OP_FAIL_RANGE : ilist_pkg::OP_SET;
          end
          ilist_pkg::CMD_INSERT: begin
            if (stat_i.range_err) begin
              op_o = ilist_pkg::OP_FAIL_RANGE;
            end else if (stat_i.full) begin
              op_o = ilist_pkg::OP_FAIL_FULL;
            end else if (stat_i.ins_direct) begin
              op_o = ilist_pkg::OP_INS_WR;
            end else begin
              op_o    = ilist_pkg::OP_UP_START;
              state_d = S_UP;
            end
          end
          ilist_pkg::CMD_REMOVE: begin
            if (stat_i.range_err) begin
              op_o = ilist_pkg::OP_FAIL_RANGE;
            end else if (stat_i.dn_none) begin
              op_o = ilist_pkg::OP_DEC;
            end else begin
              op_o    = ilist_pkg::OP_DN_START;
              state_d = S_DN;
            end
          end
          ilist_pkg::CMD_FIND: begin
            if (!stat_i.cnt_zero) begin
              op_o    = ilist_pkg::OP_FIND_START;
              state_d = S_FIND;
            end
          end
          default: begin
          end
        endcase
      end
      S_GET: begin
        op_o    = ilist_pkg::OP_GET_DONE;
        state_d = S_OUT;
      end
      S_UP: begin
        op_o = ilist_pkg::OP_UP_STEP;
        if (stat_i.up_last) begin
          state_d = S_INS;
        end
      end
      S_INS: begin
        op_o    = ilist_pkg::OP_INS_WR;
        state_d = S_OUT;
      end
      S_DN: begin
        if (stat_i.dn_last) begin
          op_o    = ilist_pkg::OP_DN_LAST;
          state_d = S_OUT;
        end else begin
          op_o = ilist_pkg::OP_DN_STEP;
        end
      end
      S_FIND: begin
        op_o = ilist_pkg::OP_FIND_STEP;
        if (stat_i.match || stat_i.find_last) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

endmodule

### rtl/indexed_list_insert_remove_find_top.sv
// Indexed list top level: stream ports around the controller and datapath.
//
//   channel   dir  tdata fields (lsb first)
//   s_axis    in   cmd[2:0] index[7:3] value[39:8]
//   m_axis    out  read_value[31:0] found_index[36:32] status[38:37] count[43:39]
//
// One beat at a time: accept, check, walk, then hold the result beat.
// Get reads the entry; set and failed commands end at the check; insert shifts entries
// up from the index (an append just writes), remove shifts down, find scans to a match.
// The walk moves one entry a cycle through the one-read, one-write entry memory.
// Reset clears the live count and the controller; entries are undefined until written.
// A stalled result beat holds the block; no new beat is taken until it leaves.
module indexed_list_insert_remove_find_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [ilist_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // cmd, index, value
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [ilist_pkg::M_TDATA_W-1:0]     m_axis_tdata   // read_value, found_index,
                                                             // status, count, zero pad
);

  localparam int unsigned IDX_LO = ilist_pkg::CMD_W;
  localparam int unsigned VAL_LO = IDX_LO + ilist_pkg::INDEX_W;
  localparam int unsigned RES_W  = ilist_pkg::VALUE_W + ilist_pkg::INDEX_W
                                 + ilist_pkg::STATUS_W + ilist_pkg::COUNT_W;

  ilist_pkg::dp_op_e                     op;
  ilist_pkg::dp_stat_t                   stat;
  logic [ilist_pkg::VALUE_W-1:0]         read_value;
  logic signed [ilist_pkg::INDEX_W-1:0]  found_index;
  logic [ilist_pkg::STATUS_W-1:0]        status;
  logic [ilist_pkg::COUNT_W-1:0]         count;

  ilist_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .op_o        (op)
  );

  ilist_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .cmd_i         (s_axis_tdata[IDX_LO-1:0]),
    .index_i       (s_axis_tdata[VAL_LO-1:IDX_LO]),
    .value_i       (s_axis_tdata[VAL_LO+ilist_pkg::VALUE_W-1:VAL_LO]),
    .stat_o        (stat),
    .read_value_o  (read_value),
    .found_index_o (found_index),
    .status_o      (status),
    .count_o       (count)
  );

  assign m_axis_tdata = {{(ilist_pkg::M_TDATA_W-RES_W){1'b0}},
                         count, status, found_index, read_value};

endmodule

### tb/tb_top.sv
// Self-checking bench for the indexed list: directed and random command beats against a list model.
module tb_top;
  import ilist_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned RANDOM_BEATS = 530;
  localparam int unsigned PHASE_BEATS  = 60;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned REPORT_MAX   = 10;

  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  found_index;
    logic [VALUE_W-1:0]  read_value;
  } list_result_t;

  class list_scoreboard;
    logic [VALUE_W-1:0] entries [DEPTH];
    int unsigned        live;
    list_result_t       pending [$];
    int unsigned        mismatches;

    function new();
      live       = 0;
      mismatches = 0;
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [INDEX_W-1:0] idx,
                               logic [VALUE_W-1:0] val);
      list_result_t r;
      bit           hit;
      r.read_value  = '0;
      r.found_index = FOUND_NONE;
      r.status      = ST_OK;
      hit           = 1'b0;
      case (cmd)
        CMD_GET: begin
          if (idx >= live) r.status = ST_RANGE;
          else r.read_value = entries[idx];
        end
        CMD_SET: begin
          if (idx >= live) r.status = ST_RANGE;
          else entries[idx] = val;
        end
        CMD_INSERT: begin
          if (idx > live) begin
            r.status = ST_RANGE;
          end else if (live >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            for (int k = live; k > idx; k--) entries[k] = entries[k-1];
            entries[idx] = val;
            live++;
          end
        end
        CMD_REMOVE: begin
          if (idx >= live) begin
            r.status = ST_RANGE;
          end else begin
            for (int k = idx; k + 1 < live; k++) entries[k] = entries[k+1];
            live--;
          end
        end
        CMD_FIND: begin
          for (int k = 0; k < live; k++) begin
            if (!hit && entries[k] == val) begin
              r.found_index = INDEX_W'(k);
              hit           = 1'b1;
            end
          end
        end
        default: ;
      endcase
      r.count = COUNT_W'(live);
      pending.push_back(r);
    endfunction

    function void check_beat(logic [M_TDATA_W-1:0] beat);
      list_result_t got;
      list_result_t want;
      got = beat[$bits(list_result_t)-1:0];
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result beat: read=%h found=%0d status=%0d count=%0d",
                   got.read_value, $signed(got.found_index), got.status, got.count);
        return;
      end
      want = pending.pop_front();
      if (got.read_value !== want.read_value || got.found_index !== want.found_index ||
          got.status !== want.status || got.count !== want.count) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("result beat differs: expected read=%h found=%0d status=%0d count=%0d, %s",
                   want.read_value, $signed(want.found_index), want.status, want.count,
                   $sformatf("got read=%h found=%0d status=%0d count=%0d",
                             got.read_value, $signed(got.found_index), got.status,
                             got.count));
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;   // cmd, index, value
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;   // read_value, found_index, status, count, zero pad

  list_scoreboard       sb = new();
  bit                   stall_request;
  int unsigned          burst_left;
  logic [VALUE_W-1:0]   value_pool [6];

  indexed_list_insert_remove_find_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic push_command(input logic [CMD_W-1:0] cmd, input logic [INDEX_W-1:0] idx,
                              input logic [VALUE_W-1:0] val);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {val, idx, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(cmd, idx, val);
    burst_left--;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata);
  end

  // Receiver: rotate through stall patterns, hold off for a long stretch on request.
  initial begin
    int unsigned cyc;
    cyc           = 0;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_request) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        stall_request = 1'b0;
      end else begin
        case ((cyc / 97) % 4)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= (cyc % 4) != 0;
          2:       m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= $urandom_range(0, 4) == 0;
        endcase
        cyc++;
      end
    end
  end

  initial begin
    int unsigned idle;
    idle = 0;
    wait (rst_ni);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle = 0;
      else idle++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned        roll;
    int unsigned        t_ins;
    int unsigned        t_rem;
    bit                 growing;
    logic [CMD_W-1:0]   cmd;
    logic [INDEX_W-1:0] idx;
    logic [VALUE_W-1:0] val;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    stall_request = 1'b0;
    burst_left    = 0;
    value_pool[0] = '0;
    value_pool[1] = '1;
    value_pool[2] = 32'h0000_0001;
    value_pool[3] = 32'h8000_0000;
    value_pool[4] = $urandom;
    value_pool[5] = $urandom;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty list first: every indexed command out of range, find misses; then directed beats and unused codes.
    push_command(CMD_GET,    5'd0,  32'h0);
    push_command(CMD_SET,    5'd0,  32'hDEAD_BEEF);
    push_command(CMD_REMOVE, 5'd0,  32'h0);
    push_command(CMD_FIND,   5'd0,  32'h0);
    push_command(CMD_INSERT, 5'd1,  32'h1);
    push_command(CMD_INSERT, 5'd0,  32'hFFFF_FFFF);
    push_command(CMD_INSERT, 5'd1,  32'h0);
    push_command(CMD_INSERT, 5'd0,  32'hA5A5_A5A5);
    push_command(CMD_SET,    5'd1,  32'h1234_5678);
    push_command(CMD_GET,    5'd2,  32'h0);
    push_command(CMD_GET,    5'd16, 32'h0);
    push_command(CMD_FIND,   5'd0,  32'hFFFF_FFFF);
    push_command(CMD_FIND,   5'd0,  32'h0);
    push_command(CMD_GET,    5'd0,  32'h0);
    push_command(CMD_REMOVE, 5'd2,  32'h0);
    push_command(CMD_INSERT, 5'd2,  32'h8000_0000);
    push_command(CMD_REMOVE, 5'd0,  32'h0);
    for (int c = int'(CMD_FIND) + 1; c < (1 << CMD_W); c++)
      push_command(CMD_W'(c), 5'd16, $urandom);

    // Alternate growing and shrinking phases so full and empty are both reached.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == 200) stall_request = 1'b1;
      growing = ((n / PHASE_BEATS) % 2) == 0;
      t_ins   = growing ? 60 : 5;
      t_rem   = 65;
      roll    = $urandom_range(0, 99);
      if (roll < t_ins)      cmd = CMD_INSERT;
      else if (roll < t_rem) cmd = CMD_REMOVE;
      else if (roll < 75)    cmd = CMD_GET;
      else if (roll < 83)    cmd = CMD_SET;
      else if (roll < 97)    cmd = CMD_FIND;
      else                   cmd = CMD_W'(CMD_FIND + $urandom_range(1, 3));

      if ($urandom_range(0, 99) < 90) begin
        if (cmd == CMD_INSERT) idx = INDEX_W'($urandom_range(0, sb.live));
        else if (sb.live == 0) idx = '0;
        else idx = INDEX_W'($urandom_range(0, sb.live - 1));
      end else begin
        idx = INDEX_W'($urandom_range(0, DEPTH));
      end

      if ($urandom_range(0, 9) < 5) val = value_pool[$urandom_range(0, 5)];
      else val = $urandom;

      push_command(cmd, idx, val);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### indexed_list_insert_remove_find_top.f
+incdir+rtl
rtl/ilist_pkg.sv
rtl/ilist_dp.sv
rtl/ilist_ctrl.sv
rtl/indexed_list_insert_remove_find_top.sv
tb/tb_top.sv
